[rtl/core/bls_pkg.sv]
// Shared constants and types for the Bresenham line stepper.
`default_nettype none

package bls_pkg;

  // Default coordinate width in bits.
  localparam int COORD_BITS_DEFAULT = 16;

  // Command codes carried in the input tuser bit.
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Control flags handed from the setup stage to the stepping stage.
  typedef struct packed {
    logic start;           // word is a start command
    logic major_negative;  // major axis walks downward
    logic minor_negative;  // minor axis walks downward
    logic axes_swapped;    // steep line, y is the major axis
    logic line_active;     // new line has at least one pixel
  } bls_flags_t;

endpackage

`default_nettype wire

[rtl/core/bls_setup.sv]
// Setup stage: decodes a command word and registers the line parameters.
`default_nettype none

module bls_setup #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Upstream side
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire logic                         opcode,
  input  wire logic [COORD_BITS-1:0]        x_start,
  input  wire logic [COORD_BITS-1:0]        y_start,
  input  wire logic [COORD_BITS-1:0]        x_end,
  input  wire logic [COORD_BITS-1:0]        y_end,
  // Downstream side
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      bls_pkg::bls_flags_t          flags,
  output      logic [COORD_BITS-1:0]        major_pos,
  output      logic [COORD_BITS-1:0]        minor_pos,
  output      logic [COORD_BITS-1:0]        major_end,
  output      logic signed [COORD_BITS+2:0] error_term,
  output      logic [COORD_BITS+1:0]        twice_minor_delta,
  output      logic signed [COORD_BITS+2:0] twice_delta_difference
);

  localparam int DIFF_BITS = COORD_BITS + 1;

  logic signed [DIFF_BITS-1:0] dx;
  logic signed [DIFF_BITS-1:0] dy;
  logic [COORD_BITS-1:0]       dx_abs;
  logic [COORD_BITS-1:0]       dy_abs;
  logic [COORD_BITS-1:0]       d_major;
  logic [COORD_BITS-1:0]       d_minor;
  logic                        steep;
  bls_pkg::bls_flags_t         flags_next;

  // Signed spans and their magnitudes; a magnitude always fits the coordinate width.
  always_comb begin
    dx = $signed({x_end[COORD_BITS-1], x_end}) - $signed({x_start[COORD_BITS-1], x_start});
    dy = $signed({y_end[COORD_BITS-1], y_end}) - $signed({y_start[COORD_BITS-1], y_start});
    dx_abs = dx[DIFF_BITS-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    dy_abs = dy[DIFF_BITS-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    steep  = (dy_abs >= dx_abs);
    d_major = steep ? dy_abs : dx_abs;
    d_minor = steep ? dx_abs : dy_abs;
  end

  // Flags for the stepping stage.
  always_comb begin
    flags_next.start          = (opcode == bls_pkg::OP_START);
    flags_next.axes_swapped   = steep;
    flags_next.major_negative = steep ? dy[DIFF_BITS-1] : dx[DIFF_BITS-1];
    flags_next.minor_negative = steep ? dx[DIFF_BITS-1] : dy[DIFF_BITS-1];
    flags_next.line_active    = (d_major != '0);
  end

  assign in_ready = !out_valid || out_ready;

  // Stage valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Registered line parameters.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      flags                  <= flags_next;
      major_pos              <= steep ? y_start : x_start;
      minor_pos              <= steep ? x_start : y_start;
      major_end              <= steep ? y_end : x_end;
      twice_minor_delta      <= {1'b0, d_minor, 1'b0};
      error_term             <= $signed({2'b00, d_minor, 1'b0}) - $signed({3'b000, d_major});
      twice_delta_difference <= $signed({2'b00, d_minor, 1'b0})
                                - $signed({2'b00, d_major, 1'b0});
    end
  end

endmodule

`default_nettype wire

[rtl/core/bls_step.sv]
// Stepping stage: holds the line state and registers one result per word.
`default_nettype none

module bls_step #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // From the setup stage
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire bls_pkg::bls_flags_t          flags,
  input  wire logic [COORD_BITS-1:0]        load_major_pos,
  input  wire logic [COORD_BITS-1:0]        load_minor_pos,
  input  wire logic [COORD_BITS-1:0]        load_major_end,
  input  wire logic signed [COORD_BITS+2:0] load_error_term,
  input  wire logic [COORD_BITS+1:0]        load_twice_minor_delta,
  input  wire logic signed [COORD_BITS+2:0] load_twice_delta_difference,
  // Result side
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      logic [COORD_BITS-1:0]        pixel_x,
  output      logic [COORD_BITS-1:0]        pixel_y,
  output      logic                         point_valid,
  output      logic                         last
);

  localparam int ERR_BITS = COORD_BITS + 3;

  // Line state.
  logic [COORD_BITS-1:0]      major_pos;
  logic [COORD_BITS-1:0]      minor_pos;
  logic [COORD_BITS-1:0]      major_end;
  logic signed [ERR_BITS-1:0] error_term;
  logic [COORD_BITS+1:0]      twice_minor_delta;
  logic signed [ERR_BITS-1:0] twice_delta_difference;
  logic                       major_negative;
  logic                       minor_negative;
  logic                       axes_swapped;
  logic                       line_active;

  // Current view: freshly loaded values on a start, held state otherwise.
  logic [COORD_BITS-1:0]      cur_major;
  logic [COORD_BITS-1:0]      cur_minor;
  logic [COORD_BITS-1:0]      cur_end;
  logic signed [ERR_BITS-1:0] cur_error;
  logic [COORD_BITS+1:0]      cur_tmd;
  logic signed [ERR_BITS-1:0] cur_tdd;
  logic                       cur_major_neg;
  logic                       cur_minor_neg;
  logic                       cur_swapped;
  logic                       cur_active;

  logic [COORD_BITS-1:0]      major_pos_next;
  logic [COORD_BITS-1:0]      minor_pos_next;
  logic signed [ERR_BITS-1:0] error_term_next;
  logic                       line_active_next;
  logic                       last_next;
  logic                       accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (flags.start) begin
      cur_major     = load_major_pos;
      cur_minor     = load_minor_pos;
      cur_end       = load_major_end;
      cur_error     = load_error_term;
      cur_tmd       = load_twice_minor_delta;
      cur_tdd       = load_twice_delta_difference;
      cur_major_neg = flags.major_negative;
      cur_minor_neg = flags.minor_negative;
      cur_swapped   = flags.axes_swapped;
      cur_active    = flags.line_active;
    end else begin
      cur_major     = major_pos;
      cur_minor     = minor_pos;
      cur_end       = major_end;
      cur_error     = error_term;
      cur_tmd       = twice_minor_delta;
      cur_tdd       = twice_delta_difference;
      cur_major_neg = major_negative;
      cur_minor_neg = minor_negative;
      cur_swapped   = axes_swapped;
      cur_active    = line_active;
    end
  end

  // One Bresenham step: the minor axis moves when the error is positive.
  always_comb begin
    if (cur_error > 0) begin
      error_term_next = cur_error + cur_tdd;
      minor_pos_next  = cur_minor_neg ? cur_minor - 1'b1 : cur_minor + 1'b1;
    end else begin
      error_term_next = cur_error + $signed({1'b0, cur_tmd});
      minor_pos_next  = cur_minor;
    end
    major_pos_next   = cur_major_neg ? cur_major - 1'b1 : cur_major + 1'b1;
    last_next        = (major_pos_next == cur_end);
    line_active_next = cur_active && !last_next;
  end

  // State update on every accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (accept) begin
      line_active <= line_active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      major_end              <= cur_end;
      twice_minor_delta      <= cur_tmd;
      twice_delta_difference <= cur_tdd;
      major_negative         <= cur_major_neg;
      minor_negative         <= cur_minor_neg;
      axes_swapped           <= cur_swapped;
      if (cur_active) begin
        major_pos  <= major_pos_next;
        minor_pos  <= minor_pos_next;
        error_term <= error_term_next;
      end else begin
        major_pos  <= cur_major;
        minor_pos  <= cur_minor;
        error_term <= cur_error;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      point_valid <= cur_active;
      last        <= cur_active && last_next;
      if (!cur_active) begin
        pixel_x <= '0;
        pixel_y <= '0;
      end else if (cur_swapped) begin
        pixel_x <= cur_minor;
        pixel_y <= cur_major;
      end else begin
        pixel_x <= cur_major;
        pixel_y <= cur_minor;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/bresenham_line_stepper.sv]
// Top level of the Bresenham line stepper.
//
// Input words arrive on the s_ stream. tuser carries the command: start a
// new line from the endpoints in tdata, or advance to the next pixel. Every
// input word gives exactly one result word on the m_ stream: the pixel
// coordinates in tdata, point_valid in tuser and the final-pixel mark in
// tlast. A start gives the first pixel of the new line; the end point itself
// is never given. A zero-length line, or an advance once the line is done,
// gives a word with point_valid low and zero coordinates.
// The path has two register stages. The word is first registered in the setup
// register (spans, axis choice, error seed) and then in the stepping register
// that holds the line state, which offers the result. Throughput is one word
// per cycle while the receiver takes each result; the step stage updates the
// line state on every accepted word. Reset empties both stages and ends any
// line in progress. When the receiver stalls, the result register holds its
// word and the setup register takes one more word only if it is empty; s_tready
// then stays low until the result is taken.
`default_nettype none

module bresenham_line_stepper #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // Command stream
  input  wire logic                                 s_tvalid,
  output      logic                                 s_tready,
  // tdata fields from bit 0: x_start, y_start, x_end, y_end, zero fill
  input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]    s_tdata,
  // tuser fields from bit 0: opcode
  input  wire logic                                 s_tuser,
  // Pixel stream
  output      logic                                 m_tvalid,
  input  wire logic                                 m_tready,
  // tdata fields from bit 0: pixel_x, pixel_y, zero fill
  output      logic [((2*COORD_BITS+7)/8)*8-1:0]    m_tdata,
  // tuser fields from bit 0: point_valid
  output      logic                                 m_tuser,
  output      logic                                 m_tlast
);

  localparam int OUT_DATA_BITS = ((2*COORD_BITS+7)/8)*8;

  logic                         setup_valid;
  logic                         setup_ready;
  bls_pkg::bls_flags_t          setup_flags;
  logic [COORD_BITS-1:0]        setup_major_pos;
  logic [COORD_BITS-1:0]        setup_minor_pos;
  logic [COORD_BITS-1:0]        setup_major_end;
  logic signed [COORD_BITS+2:0] setup_error_term;
  logic [COORD_BITS+1:0]        setup_twice_minor_delta;
  logic signed [COORD_BITS+2:0] setup_twice_delta_difference;
  logic [COORD_BITS-1:0]        pixel_x;
  logic [COORD_BITS-1:0]        pixel_y;

  // Decode and register the line setup.
  bls_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .clk                    (clk),
    .rst                    (rst),
    .in_valid               (s_tvalid),
    .in_ready               (s_tready),
    .opcode                 (s_tuser),
    .x_start                (s_tdata[COORD_BITS-1:0]),
    .y_start                (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .x_end                  (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .y_end                  (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .out_valid              (setup_valid),
    .out_ready              (setup_ready),
    .flags                  (setup_flags),
    .major_pos              (setup_major_pos),
    .minor_pos              (setup_minor_pos),
    .major_end              (setup_major_end),
    .error_term             (setup_error_term),
    .twice_minor_delta      (setup_twice_minor_delta),
    .twice_delta_difference (setup_twice_delta_difference)
  );

  // Walk the line and register one result per word.
  bls_step #(
    .COORD_BITS (COORD_BITS)
  ) u_step (
    .clk                         (clk),
    .rst                         (rst),
    .in_valid                    (setup_valid),
    .in_ready                    (setup_ready),
    .flags                       (setup_flags),
    .load_major_pos              (setup_major_pos),
    .load_minor_pos              (setup_minor_pos),
    .load_major_end              (setup_major_end),
    .load_error_term             (setup_error_term),
    .load_twice_minor_delta      (setup_twice_minor_delta),
    .load_twice_delta_difference (setup_twice_delta_difference),
    .out_valid                   (m_tvalid),
    .out_ready                   (m_tready),
    .pixel_x                     (pixel_x),
    .pixel_y                     (pixel_y),
    .point_valid                 (m_tuser),
    .last                        (m_tlast)
  );

  // Pack the pixel word, zero filled to whole bytes.
  assign m_tdata = OUT_DATA_BITS'({pixel_y, pixel_x});

endmodule

`default_nettype wire
